### sv/krt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg
// shared types and constants of the keyed record table
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int CAPACITY_DEFAULT = 128;

    localparam int KEY_W   = 32;
    localparam int OWNER_W = 64;
    localparam int OP_W    = 2;
    localparam int COUNT_W = 8;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK   = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [OWNER_W-1:0]      owner;
        logic                    flag;
    } entry_t;

endpackage : krt_pkg
`default_nettype wire

### sv/keyed_record_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_record_table
// record table in one synchronous memory with linear key search,
// append on add, gap-closing shift on remove and flag update on mark
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         request: opcode, record_key, owner_tag, flag_value
//  m_axis    out        response: success, record_count
//
//  a request takes a search step through the records and an action step,
//  plus, for remove, a shift of the later records one place down, and a
//  step to post the response and return to idle; the search and the shift
//  read the record memory through its single read port
//  reset empties the table at once; entries are only read below the count
//  a waiting response holds the block in its last step until it is taken
// ----------------------------------------------------------------------------
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode[1:0], record_key[33:2], owner_tag[97:34], flag_value[98], zero fill
    input  wire logic [103:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // success[0], record_count[8:1], zero fill
    output logic [15:0]       m_axis_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SRCH = 3'd1;
    localparam logic [2:0] ST_ACT  = 3'd2;
    localparam logic [2:0] ST_SHFT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic                    found_reg, found_next;
    logic                    ok_reg, ok_next;
    logic                    out_vld_reg, out_vld_next;
    logic                    out_ok_reg, out_ok_next;
    logic [COUNT_W-1:0]      out_cnt_reg, out_cnt_next;

    logic [OP_W-1:0]         op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [OWNER_W-1:0]      owner_reg;
    logic                    flag_reg;

    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    entry_t                  wr_data;

    logic                    in_xfer;
    logic                    hit;
    logic [CW-1:0]           pos_plus1;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign hit       = cmp_vld_reg && (rd_data_reg.key == key_reg);
    assign pos_plus1 = CW'(pos_reg) + CW'(1);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'b0, out_cnt_reg, out_ok_reg};

    // record memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg    <= s_axis_tdata[1:0];
            key_reg   <= s_axis_tdata[33:2];
            owner_reg <= s_axis_tdata[97:34];
            flag_reg  <= s_axis_tdata[98];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        ok_next      = ok_reg;
        out_vld_next = out_vld_reg;
        out_ok_next  = out_ok_reg;
        out_cnt_next = out_cnt_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = rd_data_reg;

        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next     = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (hit)
                begin
                    found_next   = 1'b1;
                    pos_next     = cmp_idx_reg;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_ACT;
                end
                else if (idx_reg < fill_reg)
                begin
                    rd_en        = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                    idx_next     = idx_reg + CW'(1);
                end
                else
                begin
                    found_next   = 1'b0;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_ACT;
                end
            end
            ST_ACT:
            begin
                ok_next    = 1'b0;
                state_next = ST_DONE;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (!found_reg && (fill_reg < CAP_C))
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = fill_reg[AW-1:0];
                            wr_data.key   = key_reg;
                            wr_data.owner = owner_reg;
                            wr_data.flag  = 1'b0;
                            fill_next     = fill_reg + CW'(1);
                            ok_next       = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            idx_next     = pos_plus1;
                            cmp_vld_next = 1'b0;
                            state_next   = ST_SHFT;
                        end
                    end
                    OP_MARK:
                    begin
                        if (found_reg)
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = pos_reg;
                            wr_data.flag = flag_reg;
                            ok_next      = 1'b1;
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_SHFT:
            begin
                // move the record read last cycle one place down
                if (cmp_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cmp_idx_reg - AW'(1);
                    wr_data = rd_data_reg;
                end
                if (idx_reg < fill_reg)
                begin
                    rd_en        = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                    idx_next     = idx_reg + CW'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    fill_next    = fill_reg - CW'(1);
                    ok_next      = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next = 1'b1;
                    out_ok_next  = ok_reg;
                    out_cnt_next = COUNT_W'(fill_reg);
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        ok_reg      <= ok_next;
        out_ok_reg  <= out_ok_next;
        out_cnt_reg <= out_cnt_next;
    end

endmodule : keyed_record_table
`default_nettype wire

### tb/keyed_record_table_checker.sv
// ----------------------------------------------------------------------------
// keyed_record_table_checker
// watches the request and response channels of the keyed record table,
// predicts each response from its own copy of the table and compares the
// responses in order, field by field
// ----------------------------------------------------------------------------
module keyed_record_table_checker
    import krt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    // opcode[1:0], record_key[33:2], owner_tag[97:34], flag_value[98], zero fill
    input  wire logic [103:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // success[0], record_count[8:1], zero fill
    input  wire logic [15:0]  m_axis_tdata,
    output int                fail_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_LSB   = OP_W;
    localparam int OWNER_LSB = KEY_LSB + KEY_W;
    localparam int FLAG_BIT  = OWNER_LSB + OWNER_W;

    typedef struct packed {
        logic               success;
        logic [COUNT_W-1:0] record_count;
    } response_t;

    logic signed [KEY_W-1:0] table_keys   [CAPACITY];
    logic [OWNER_W-1:0]      table_owners [CAPACITY];
    logic                    table_flags  [CAPACITY];
    int                      held;
    response_t               awaited_responses [$];

    function automatic response_t apply_request(
        input logic [OP_W-1:0]       op,
        input logic signed [KEY_W-1:0] key,
        input logic [OWNER_W-1:0]    tag,
        input logic                  flag
    );
        response_t r;
        int        pos;
        pos = held;
        for (int i = held - 1; i >= 0; i--)
        begin
            if (table_keys[i] == key)
                pos = i;
        end
        r.success = 1'b0;
        case (op)
            OP_ADD:
            begin
                if (held < CAPACITY && pos == held)
                begin
                    table_keys[held]   = key;
                    table_owners[held] = tag;
                    table_flags[held]  = 1'b0;
                    held++;
                    r.success = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos < held)
                begin
                    for (int j = pos; j + 1 < held; j++)
                    begin
                        table_keys[j]   = table_keys[j + 1];
                        table_owners[j] = table_owners[j + 1];
                        table_flags[j]  = table_flags[j + 1];
                    end
                    held--;
                    r.success = 1'b1;
                end
            end
            OP_MARK:
            begin
                if (pos < held)
                begin
                    table_flags[pos] = flag;
                    r.success = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.record_count = COUNT_W'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        response_t got;
        if (!rst_n)
        begin
            held = 0;
            awaited_responses.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.success      = m_axis_tdata[0];
                got.record_count = m_axis_tdata[COUNT_W:1];
                if (awaited_responses.size() == 0)
                begin
                    $error("response transfer with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (got.success !== want.success)
                    begin
                        $error("success: expected %0d, actual %0d", want.success, got.success);
                        fail_count++;
                    end
                    if (got.record_count !== want.record_count)
                    begin
                        $error("record_count: expected %0d, actual %0d",
                               want.record_count, got.record_count);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_responses.push_back(apply_request(
                    s_axis_tdata[OP_W-1:0],
                    s_axis_tdata[OWNER_LSB-1:KEY_LSB],
                    s_axis_tdata[FLAG_BIT-1:OWNER_LSB],
                    s_axis_tdata[FLAG_BIT]));
        end
        outstanding = awaited_responses.size();
    end

endmodule

### tb/keyed_record_table_test.sv
// ----------------------------------------------------------------------------
// keyed_record_table_test
// drives directed and random add, remove and mark requests into the keyed
// record table with random gaps on both channels, fills and empties the
// table, and reports the verdict of the checker
// ----------------------------------------------------------------------------
module keyed_record_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import krt_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEFAULT;
    localparam int POOL_SIZE   = 192;
    localparam int SEGMENTS    = 8;
    localparam int SEG_ITEMS   = 250;
    localparam int CYCLE_LIMIT = 3_000_000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // opcode[1:0], record_key[33:2], owner_tag[97:34], flag_value[98], zero fill
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // success[0], record_count[8:1], zero fill
    logic [15:0]  m_axis_tdata;

    int fail_count;
    int outstanding;
    int cycles = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

    keyed_record_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    keyed_record_table_checker #(
        .CAPACITY(CAPACITY)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("keyed_record_table_test failed");
            $finish;
        end
    end

    // response side: random stall before each transfer
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                stall_left = rx_calm ? 0 : $urandom_range(0, 10);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic issue_request(
        input logic [OP_W-1:0]         op,
        input logic signed [KEY_W-1:0] key,
        input logic [OWNER_W-1:0]      tag,
        input logic                    flag
    );
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, flag, tag, key, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic wait_for_responses();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
        int                      roll;
        int                      cursor;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 32'sh0000_0000;
        key_pool[3] = -32'sd1;
        key_pool[4] = 32'sd1;
        for (int i = 5; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table, then append, duplicate, flags, removals at front, middle and end
        issue_request(OP_MARK,   0, '0, 1'b1);
        issue_request(OP_REMOVE, 0, '0, 1'b0);
        issue_request(OP_UNUSED, 0, '0, 1'b0);
        issue_request(OP_ADD,    32'sh8000_0000, '1, 1'b1);
        issue_request(OP_ADD,    32'sh7fff_ffff, '0, 1'b0);
        issue_request(OP_ADD,    0, 64'h5555_5555_5555_5555, 1'b0);
        issue_request(OP_ADD,    -32'sd1, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
        issue_request(OP_ADD,    32'sh8000_0000, 64'h1234_5678_9abc_def0, 1'b0);
        issue_request(OP_MARK,   32'sh8000_0000, '0, 1'b1);
        issue_request(OP_MARK,   32'sh7fff_ffff, '0, 1'b1);
        issue_request(OP_MARK,   32'sh7fff_ffff, '0, 1'b0);
        issue_request(OP_MARK,   1, '0, 1'b1);
        issue_request(OP_UNUSED, 0, '1, 1'b1);
        issue_request(OP_REMOVE, 0, '0, 1'b0);
        issue_request(OP_REMOVE, 32'sh8000_0000, '0, 1'b0);
        issue_request(OP_REMOVE, 0, '0, 1'b0);
        issue_request(OP_REMOVE, -32'sd1, '0, 1'b0);
        issue_request(OP_ADD,    0, '1, 1'b0);
        issue_request(OP_MARK,   0, '0, 1'b1);
        wait_for_responses();

        // segments cycle through filling, churning and emptying the table
        cursor = 0;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                case (seg % 4)
                    0:
                    begin
                        op = (roll < 85) ? OP_ADD : (roll < 90) ? OP_REMOVE :
                             (roll < 97) ? OP_MARK : OP_UNUSED;
                        if (op == OP_ADD)
                        begin
                            key    = key_pool[cursor];
                            cursor = (cursor + 1) % POOL_SIZE;
                        end
                    end
                    2:
                        op = (roll < 10) ? OP_ADD : (roll < 80) ? OP_REMOVE :
                             (roll < 95) ? OP_MARK : OP_UNUSED;
                    default:
                        op = (roll < 35) ? OP_ADD : (roll < 65) ? OP_REMOVE :
                             (roll < 95) ? OP_MARK : OP_UNUSED;
                endcase
                if ($urandom_range(0, 9) == 0)
                    key = $urandom;
                issue_request(op, key, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
            end
            if (seg % 3 == 1)
                wait_for_responses();
        end

        wait_for_responses();
        repeat (2 * CAPACITY + 10) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("keyed_record_table_test passed");
        else
            $display("keyed_record_table_test failed");
        $finish;
    end

endmodule
